[rtl/ostw_pkg.sv]
package ostw_pkg;

   localparam int FRAC_BITS_DEF = 8;

   // field widths
   localparam int STATION_W = 24;
   localparam int OFFSET_W  = 16;
   localparam int SPEED_W   = 16;
   localparam int WIN_W     = 15;
   localparam int TIME_W    = 16;

   // divisor magnitude (|lateral_speed| up to 2^15) and dividend magnitude
   localparam int DEN_W = 16;
   localparam int MAG_W = 17;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LAT_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BAND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_NEAR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_FAR   = 2'd3;

   localparam logic [WIN_W-1:0]  LAT_WINDOW_RST = 15'd384;
   localparam logic [WIN_W-1:0]  HALF_BAND_RST  = 15'd128;
   localparam logic [TIME_W-1:0] TIME_NEAR_RST  = 16'd256;
   localparam logic [TIME_W-1:0] TIME_FAR_RST   = 16'd2048;

   localparam int STATION_MAX = 8388607;
   localparam int STATION_MIN = -8388608;

   // per-item data that rides along the divider
   typedef struct packed {
      logic                        skip;
      logic signed [STATION_W-1:0] station;
      logic signed [SPEED_W-1:0]   speed;
   } ostw_side_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic             qbit;
   } ostw_dstep_type;

   // one restoring division step: shift in one numerator bit, subtract if it fits
   function automatic ostw_dstep_type div_step(input logic [DEN_W-1:0] rem,
                                               input logic nbit,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      ostw_dstep_type r;
      trial  = {rem, nbit};
      diff   = trial - {1'b0, den};
      r.qbit = (trial >= {1'b0, den});
      r.rem  = r.qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      return r;
   endfunction

endpackage

[rtl/ostw_front.sv]
module ostw_front
   import ostw_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_unused,
   input  logic signed [STATION_W-1:0] in_station,
   input  logic signed [OFFSET_W-1:0]  in_lateral,
   input  logic signed [SPEED_W-1:0]   in_station_speed,
   input  logic signed [SPEED_W-1:0]   in_lateral_speed,
   input  logic [WIN_W-1:0]            lateral_window,
   input  logic [WIN_W-1:0]            half_band,
   output logic                        out_valid,
   output ostw_side_type               out_side,
   output logic [MAG_W-1:0]            out_a_mag,
   output logic                        out_a_neg,
   output logic [MAG_W-1:0]            out_b_mag,
   output logic                        out_b_neg,
   output logic [DEN_W-1:0]            out_den,
   output logic                        out_den_neg
);

   localparam int DW = OFFSET_W + 2;

   logic signed [DW-1:0]  h_ext;
   logic signed [DW-1:0]  l_ext;
   logic signed [DW-1:0]  diff_a;
   logic signed [DW-1:0]  diff_b;
   logic signed [DW-1:0]  abs_a;
   logic signed [DW-1:0]  abs_b;
   logic [OFFSET_W:0]     l_abs;
   logic [SPEED_W:0]      lv_abs;

   logic                  valid_ff;
   ostw_side_type         side_ff, side_in;
   logic [MAG_W-1:0]      a_mag_ff, b_mag_ff;
   logic                  a_neg_ff, b_neg_ff;
   logic [DEN_W-1:0]      den_ff;
   logic                  den_neg_ff;

   always_comb begin
      h_ext  = $signed({{(DW-WIN_W){1'b0}}, half_band});
      l_ext  = {{(DW-OFFSET_W){in_lateral[OFFSET_W-1]}}, in_lateral};
      diff_a = h_ext - l_ext;
      diff_b = -h_ext - l_ext;
      abs_a  = diff_a[DW-1] ? -diff_a : diff_a;
      abs_b  = diff_b[DW-1] ? -diff_b : diff_b;
      l_abs  = in_lateral[OFFSET_W-1] ? -{in_lateral[OFFSET_W-1], in_lateral}
                                      : {in_lateral[OFFSET_W-1], in_lateral};
      lv_abs = in_lateral_speed[SPEED_W-1]
               ? -{in_lateral_speed[SPEED_W-1], in_lateral_speed}
               : {in_lateral_speed[SPEED_W-1], in_lateral_speed};

      side_in.skip    = in_unused
                        || (l_abs > {{(OFFSET_W+1-WIN_W){1'b0}}, lateral_window})
                        || (in_lateral_speed == '0);
      side_in.station = in_station;
      side_in.speed   = in_station_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff    <= side_in;
      a_mag_ff   <= abs_a[MAG_W-1:0];
      a_neg_ff   <= diff_a[DW-1];
      b_mag_ff   <= abs_b[MAG_W-1:0];
      b_neg_ff   <= diff_b[DW-1];
      den_ff     <= lv_abs[DEN_W-1:0];
      den_neg_ff <= in_lateral_speed[SPEED_W-1];
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_a_mag   = a_mag_ff;
   assign out_a_neg   = a_neg_ff;
   assign out_b_mag   = b_mag_ff;
   assign out_b_neg   = b_neg_ff;
   assign out_den     = den_ff;
   assign out_den_neg = den_neg_ff;

endmodule

[rtl/ostw_divpair.sv]
module ostw_divpair
   import ostw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  ostw_side_type                in_side,
   input  logic [MAG_W-1:0]             in_a_mag,
   input  logic                         in_a_neg,
   input  logic [MAG_W-1:0]             in_b_mag,
   input  logic                         in_b_neg,
   input  logic [DEN_W-1:0]             in_den,
   input  logic                         in_den_neg,
   output logic                         out_valid,
   output ostw_side_type                out_side,
   output logic [MAG_W+FRAC_BITS-1:0]   out_qa,
   output logic                         out_qa_neg,
   output logic [MAG_W+FRAC_BITS-1:0]   out_qb,
   output logic                         out_qb_neg
);

   // one quotient bit per stage, both quotients in lockstep
   localparam int QW = MAG_W + FRAC_BITS;

   logic             vld_ff   [QW];
   ostw_side_type    side_ff  [QW];
   logic [DEN_W-1:0] den_ff   [QW];
   logic             qa_neg_ff[QW];
   logic             qb_neg_ff[QW];
   logic [DEN_W-1:0] rem_a_ff [QW], rem_a_in[QW];
   logic [DEN_W-1:0] rem_b_ff [QW], rem_b_in[QW];
   logic [QW-1:0]    num_a_ff [QW], num_a_in[QW];
   logic [QW-1:0]    num_b_ff [QW], num_b_in[QW];
   logic [QW-1:0]    quo_a_ff [QW], quo_a_in[QW];
   logic [QW-1:0]    quo_b_ff [QW], quo_b_in[QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic             vld_src;
      ostw_side_type    side_src;
      logic [DEN_W-1:0] den_src;
      logic             qa_neg_src, qb_neg_src;
      logic [DEN_W-1:0] rem_a_src, rem_b_src;
      logic [QW-1:0]    num_a_src, num_b_src;
      logic [QW-1:0]    quo_a_src, quo_b_src;
      ostw_dstep_type   step_a, step_b;

      if (k == 0) begin : g_first
         assign vld_src    = in_valid;
         assign side_src   = in_side;
         assign den_src    = in_den;
         assign qa_neg_src = in_a_neg ^ in_den_neg;
         assign qb_neg_src = in_b_neg ^ in_den_neg;
         assign rem_a_src  = '0;
         assign rem_b_src  = '0;
         assign num_a_src  = {in_a_mag, {FRAC_BITS{1'b0}}};
         assign num_b_src  = {in_b_mag, {FRAC_BITS{1'b0}}};
         assign quo_a_src  = '0;
         assign quo_b_src  = '0;
      end else begin : g_next
         assign vld_src    = vld_ff[k-1];
         assign side_src   = side_ff[k-1];
         assign den_src    = den_ff[k-1];
         assign qa_neg_src = qa_neg_ff[k-1];
         assign qb_neg_src = qb_neg_ff[k-1];
         assign rem_a_src  = rem_a_ff[k-1];
         assign rem_b_src  = rem_b_ff[k-1];
         assign num_a_src  = num_a_ff[k-1];
         assign num_b_src  = num_b_ff[k-1];
         assign quo_a_src  = quo_a_ff[k-1];
         assign quo_b_src  = quo_b_ff[k-1];
      end

      always_comb begin
         step_a      = div_step(rem_a_src, num_a_src[QW-1], den_src);
         step_b      = div_step(rem_b_src, num_b_src[QW-1], den_src);
         rem_a_in[k] = step_a.rem;
         rem_b_in[k] = step_b.rem;
         num_a_in[k] = {num_a_src[QW-2:0], 1'b0};
         num_b_in[k] = {num_b_src[QW-2:0], 1'b0};
         quo_a_in[k] = {quo_a_src[QW-2:0], step_a.qbit};
         quo_b_in[k] = {quo_b_src[QW-2:0], step_b.qbit};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[k]   <= side_src;
         den_ff[k]    <= den_src;
         qa_neg_ff[k] <= qa_neg_src;
         qb_neg_ff[k] <= qb_neg_src;
         rem_a_ff[k]  <= rem_a_in[k];
         rem_b_ff[k]  <= rem_b_in[k];
         num_a_ff[k]  <= num_a_in[k];
         num_b_ff[k]  <= num_b_in[k];
         quo_a_ff[k]  <= quo_a_in[k];
         quo_b_ff[k]  <= quo_b_in[k];
      end
   end

   assign out_valid  = vld_ff[QW-1];
   assign out_side   = side_ff[QW-1];
   assign out_qa     = quo_a_ff[QW-1];
   assign out_qa_neg = qa_neg_ff[QW-1];
   assign out_qb     = quo_b_ff[QW-1];
   assign out_qb_neg = qb_neg_ff[QW-1];

endmodule

[rtl/ostw_back.sv]
module ostw_back
   import ostw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  ostw_side_type                in_side,
   input  logic [MAG_W+FRAC_BITS-1:0]   in_qa,
   input  logic                         in_qa_neg,
   input  logic [MAG_W+FRAC_BITS-1:0]   in_qb,
   input  logic                         in_qb_neg,
   input  logic [TIME_W-1:0]            time_near,
   input  logic [TIME_W-1:0]            time_far,
   output logic                         out_valid,
   output logic                         out_written,
   output logic signed [STATION_W-1:0]  out_s_enter,
   output logic signed [STATION_W-1:0]  out_s_leave,
   output logic [TIME_W-1:0]            out_t_enter,
   output logic [TIME_W-1:0]            out_t_leave
);

   localparam int QW   = MAG_W + FRAC_BITS;
   localparam int TW   = QW + 1;
   localparam int PW   = SPEED_W + TW;
   localparam int SUMW = PW - FRAC_BITS + 1;

   localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'(STATION_MAX);
   localparam logic signed [SUMW-1:0] SUM_MIN = SUMW'(STATION_MIN);

   // stage 1: signed quotients
   logic                 v1_ff;
   ostw_side_type        side1_ff;
   logic signed [TW-1:0] ta_ff, ta_in, tb_ff, tb_in;

   // stage 2: ordering and time range check
   logic                 v2_ff;
   ostw_side_type        side2_ff, side2_in;
   logic signed [TW-1:0] tmin_ff, tmin_in, tmax_ff, tmax_in;
   logic                 inside_ff, inside_in;
   logic signed [TW-1:0] near_ext, far_ext;

   // stage 3: station displacement products
   logic                        v3_ff;
   logic                        skip3_ff;
   logic                        inside3_ff;
   logic signed [STATION_W-1:0] station3_ff;
   logic signed [TW-1:0]        tmin3_ff, tmax3_ff;
   logic signed [PW-1:0]        pmin_ff, pmin_in, pmax_ff, pmax_in;

   // stage 4: floor, add, saturate
   logic                        v4_ff;
   logic                        written_ff, written_in;
   logic signed [STATION_W-1:0] s_enter_ff, s_enter_in, s_leave_ff, s_leave_in;
   logic [TIME_W-1:0]           t_enter_ff, t_enter_in, t_leave_ff, t_leave_in;
   logic signed [SUMW-1:0]      sum_min, sum_max;
   logic signed [STATION_W-1:0] sat_min, sat_max;
   logic [TIME_W-1:0]           tsat_min, tsat_max;

   function automatic logic signed [STATION_W-1:0] sat_station(
      input logic signed [SUMW-1:0] v);
      if (v > SUM_MAX) begin
         return STATION_W'(STATION_MAX);
      end else if (v < SUM_MIN) begin
         return STATION_W'(STATION_MIN);
      end
      return v[STATION_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] sat_time(input logic signed [TW-1:0] t);
      if (t[TW-1]) begin
         return '0;
      end else if (t[TW-2:TIME_W] != '0) begin
         return '1;
      end
      return t[TIME_W-1:0];
   endfunction

   always_comb begin
      ta_in = in_qa_neg ? -$signed({1'b0, in_qa}) : $signed({1'b0, in_qa});
      tb_in = in_qb_neg ? -$signed({1'b0, in_qb}) : $signed({1'b0, in_qb});
   end

   always_comb begin
      near_ext  = $signed({{(TW-TIME_W){1'b0}}, time_near});
      far_ext   = $signed({{(TW-TIME_W){1'b0}}, time_far});
      tmin_in   = (ta_ff > tb_ff) ? tb_ff : ta_ff;
      tmax_in   = (ta_ff > tb_ff) ? ta_ff : tb_ff;
      inside_in = tmin_in[TW-1] && (tmax_in > 0);
      side2_in  = side1_ff;
      side2_in.skip = side1_ff.skip || (tmax_in < near_ext) || (tmin_in > far_ext);
   end

   always_comb begin
      pmin_in = PW'(side2_ff.speed) * PW'(tmin_ff);
      pmax_in = PW'(side2_ff.speed) * PW'(tmax_ff);
   end

   always_comb begin
      // arithmetic shift right is floor division by the scale
      sum_min  = SUMW'($signed(pmin_ff[PW-1:FRAC_BITS])) + SUMW'(station3_ff);
      sum_max  = SUMW'($signed(pmax_ff[PW-1:FRAC_BITS])) + SUMW'(station3_ff);
      sat_min  = sat_station(sum_min);
      sat_max  = sat_station(sum_max);
      tsat_min = sat_time(tmin3_ff);
      tsat_max = sat_time(tmax3_ff);
      written_in = !skip3_ff;
      if (skip3_ff) begin
         s_enter_in = '0;
         s_leave_in = '0;
         t_enter_in = '0;
         t_leave_in = '0;
      end else begin
         s_enter_in = inside3_ff ? station3_ff : sat_min;
         t_enter_in = inside3_ff ? '0 : tsat_min;
         s_leave_in = sat_max;
         t_leave_in = tsat_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff    <= in_side;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      side2_ff    <= side2_in;
      tmin_ff     <= tmin_in;
      tmax_ff     <= tmax_in;
      inside_ff   <= inside_in;
      skip3_ff    <= side2_ff.skip;
      inside3_ff  <= inside_ff;
      station3_ff <= side2_ff.station;
      tmin3_ff    <= tmin_ff;
      tmax3_ff    <= tmax_ff;
      pmin_ff     <= pmin_in;
      pmax_ff     <= pmax_in;
      written_ff  <= written_in;
      s_enter_ff  <= s_enter_in;
      s_leave_ff  <= s_leave_in;
      t_enter_ff  <= t_enter_in;
      t_leave_ff  <= t_leave_in;
   end

   assign out_valid   = v4_ff;
   assign out_written = written_ff;
   assign out_s_enter = s_enter_ff;
   assign out_s_leave = s_leave_ff;
   assign out_t_enter = t_enter_ff;
   assign out_t_leave = t_leave_ff;

endmodule

[rtl/obstacle_st_window.sv]
// Station-time window of one moving obstacle.
//
// Input: pulse start with the req_ fields; an obstacle transfers at every
// clock edge with start high and busy low. busy never rises, so one
// obstacle can be taken every cycle.
// Output: one result per obstacle, shown for one cycle with rsp_valid high,
// in input order. rsp_written low means skipped and all other fields zero.
// Pipeline: one input stage, one restoring division step per quotient
// bit (17 + FRAC_BITS steps, both crossing times in parallel), then
// sign/order, multiply and saturate stages.
// Throughput: one obstacle per cycle, set by the fully pipelined divider.
// Configuration: csr_write_en with csr_index and csr_wdata writes a
// register; write only while no obstacle is in flight.
// Reset: empties the pipeline and loads the register defaults.
// The receiver cannot stall; results must be taken as they appear.
module obstacle_st_window
   import ostw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_unused,
   input  logic signed [STATION_W-1:0]  req_station,
   input  logic signed [OFFSET_W-1:0]   req_lateral,
   input  logic signed [SPEED_W-1:0]    req_station_speed,
   input  logic signed [SPEED_W-1:0]    req_lateral_speed,
   output logic                         rsp_valid,
   output logic                         rsp_written,
   output logic signed [STATION_W-1:0]  rsp_s_enter,
   output logic signed [STATION_W-1:0]  rsp_s_leave,
   output logic [TIME_W-1:0]            rsp_t_enter,
   output logic [TIME_W-1:0]            rsp_t_leave,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int QW  = MAG_W + FRAC_BITS;
   localparam int LAT = QW + 5;

   logic [WIN_W-1:0]  lat_window_ff, lat_window_in;
   logic [WIN_W-1:0]  half_band_ff, half_band_in;
   logic [TIME_W-1:0] time_near_ff, time_near_in;
   logic [TIME_W-1:0] time_far_ff, time_far_in;

   logic              accept;

   logic              f_valid;
   ostw_side_type     f_side;
   logic [MAG_W-1:0]  f_a_mag, f_b_mag;
   logic              f_a_neg, f_b_neg;
   logic [DEN_W-1:0]  f_den;
   logic              f_den_neg;

   logic              d_valid;
   ostw_side_type     d_side;
   logic [QW-1:0]     d_qa, d_qb;
   logic              d_qa_neg, d_qb_neg;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      lat_window_in = lat_window_ff;
      half_band_in  = half_band_ff;
      time_near_in  = time_near_ff;
      time_far_in   = time_far_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LAT_WINDOW: lat_window_in = csr_wdata[WIN_W-1:0];
            CSR_HALF_BAND:  half_band_in  = csr_wdata[WIN_W-1:0];
            CSR_TIME_NEAR:  time_near_in  = csr_wdata[TIME_W-1:0];
            CSR_TIME_FAR:   time_far_in   = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_window_ff <= LAT_WINDOW_RST;
         half_band_ff  <= HALF_BAND_RST;
         time_near_ff  <= TIME_NEAR_RST;
         time_far_ff   <= TIME_FAR_RST;
      end else begin
         lat_window_ff <= lat_window_in;
         half_band_ff  <= half_band_in;
         time_near_ff  <= time_near_in;
         time_far_ff   <= time_far_in;
      end
   end

   ostw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .in_unused        (req_unused),
      .in_station       (req_station),
      .in_lateral       (req_lateral),
      .in_station_speed (req_station_speed),
      .in_lateral_speed (req_lateral_speed),
      .lateral_window   (lat_window_ff),
      .half_band        (half_band_ff),
      .out_valid        (f_valid),
      .out_side         (f_side),
      .out_a_mag        (f_a_mag),
      .out_a_neg        (f_a_neg),
      .out_b_mag        (f_b_mag),
      .out_b_neg        (f_b_neg),
      .out_den          (f_den),
      .out_den_neg      (f_den_neg)
   );

   ostw_divpair #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_side    (f_side),
      .in_a_mag   (f_a_mag),
      .in_a_neg   (f_a_neg),
      .in_b_mag   (f_b_mag),
      .in_b_neg   (f_b_neg),
      .in_den     (f_den),
      .in_den_neg (f_den_neg),
      .out_valid  (d_valid),
      .out_side   (d_side),
      .out_qa     (d_qa),
      .out_qa_neg (d_qa_neg),
      .out_qb     (d_qb),
      .out_qb_neg (d_qb_neg)
   );

   ostw_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_side     (d_side),
      .in_qa       (d_qa),
      .in_qa_neg   (d_qa_neg),
      .in_qb       (d_qb),
      .in_qb_neg   (d_qb_neg),
      .time_near   (time_near_ff),
      .time_far    (time_far_ff),
      .out_valid   (rsp_valid),
      .out_written (rsp_written),
      .out_s_enter (rsp_s_enter),
      .out_s_leave (rsp_s_leave),
      .out_t_enter (rsp_t_enter),
      .out_t_leave (rsp_t_leave)
   );

   // every transfer comes out as a result with rsp_valid high
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("result missing after fixed latency");

   // an unused entry never produces a window
   a_unused_skip: assert property (@(posedge clock) disable iff (reset)
      (accept && req_unused) |-> ##LAT (rsp_valid && !rsp_written))
      else $error("unused entry produced a window");

   // skipped results carry all-zero fields
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_written) |->
         (rsp_s_enter == '0 && rsp_s_leave == '0 &&
          rsp_t_enter == '0 && rsp_t_leave == '0))
      else $error("skipped result with nonzero fields");

   // window times are ordered
   a_time_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_written) |-> (rsp_t_enter <= rsp_t_leave))
      else $error("entry time after exit time");

endmodule
